// ----- design/fms_pkg.sv -----
package fms_pkg;

    localparam int TICK_BITS = 12;
    localparam int BOUND_W   = 12;
    localparam int CMP_W     = (TICK_BITS > BOUND_W) ? TICK_BITS : BOUND_W;

    localparam int VOLT_W  = 15;
    localparam int TRIM_W  = 15;
    localparam int MUL_W   = 15;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DUTY_W  = 15;
    localparam int RATE_W  = 16;
    localparam int TRIG_W  = 7;
    localparam int TICKC_W = 10;
    localparam int STEP_W  = 12;
    localparam int BOOST_W = 14;
    localparam int CFG_W   = 14;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_HOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_DUTY    = 3'd5;

    localparam logic [TRIG_W-1:0]  RST_TRIGGER_COUNT = 7'd10;
    localparam logic [TICKC_W-1:0] RST_PRE_HOLD      = 10'd150;
    localparam logic [TICKC_W-1:0] RST_FLIP_TICKS    = 10'd160;
    localparam logic [TICKC_W-1:0] RST_POST_HOLD     = 10'd120;
    localparam logic [STEP_W-1:0]  RST_RATE_STEP     = 12'd349;
    localparam logic [BOOST_W-1:0] RST_BOOST_DUTY    = 14'd2621;

    // trim = 1.5892 - 0.2448 * V, Q28 intercept, Q16 slope
    localparam logic [28:0]       TRIM_OFFSET = 29'd426597627;
    localparam logic [MUL_W-1:0]  TRIM_SLOPE  = 15'd16043;
    localparam logic [29:0]       ROUND_Q14   = 30'd8192;
    localparam logic [MUL_W-1:0]  K_030       = 15'd19661;
    localparam logic [MUL_W-1:0]  K_015       = 15'd9830;
    localparam logic [PROD_W:0]   ROUND_Q16   = 31'd32768;
    localparam logic [DUTY_W-1:0] DUTY_MAX    = 15'h7FFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRIM,
        S_SCALE,
        S_FIN
    } t_state;

endpackage

// ----- design/fms_in_if.sv -----
interface fms_in_if;
    logic                          valid;
    logic                          ready;
    logic                          flip_button;
    logic                          angle_mode;
    logic [fms_pkg::VOLT_W-1:0]    battery_volts;
    logic                          abort;

    modport source (
        output valid, flip_button, angle_mode, battery_volts, abort,
        input  ready
    );
    modport sink (
        input  valid, flip_button, angle_mode, battery_volts, abort,
        output ready
    );
endinterface

// ----- design/fms_out_if.sv -----
interface fms_out_if;
    logic                               valid;
    logic                               ready;
    logic                               flip_active;
    logic signed [fms_pkg::RATE_W-1:0]  roll_rate_ref;
    logic [fms_pkg::DUTY_W-1:0]         thrust_duty;
    logic                               attitude_reset;
    logic                               flip_done;

    modport source (
        output valid, flip_active, roll_rate_ref, thrust_duty, attitude_reset, flip_done,
        input  ready
    );
    modport sink (
        input  valid, flip_active, roll_rate_ref, thrust_duty, attitude_reset, flip_done,
        output ready
    );
endinterface

// ----- design/fms_mul.sv -----
module fms_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [fms_pkg::MUL_W-1:0]     i_a,
    input  logic [fms_pkg::MUL_W-1:0]     i_b,
    output logic [fms_pkg::PROD_W-1:0]    o_p
);

    logic [fms_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ----- design/flip_maneuver_sequencer.sv -----
// Each item goes through the trim, scale and finish steps; its result is
// registered on leaving finish, and a new item is taken only in idle. Each
// item uses the shared multiplier twice (trim, then trim scaling).
// A result not yet taken holds the sequencer in its last step.
// Reset: synchronous, active low; clears flip state, press count and the
// result valid flag, and loads the register defaults.
module flip_maneuver_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fms_in_if.sink                            i_item,
    fms_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [fms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fms_pkg::CFG_W-1:0]         i_cfg_data
);

    fms_pkg::t_state r_state, n_state;

    logic [fms_pkg::TRIG_W-1:0]  r_trig;
    logic [fms_pkg::TICKC_W-1:0] r_pre, r_flip, r_post;
    logic [fms_pkg::STEP_W-1:0]  r_step;
    logic [fms_pkg::BOOST_W-1:0] r_boost;

    logic                            r_running, n_running;
    logic [fms_pkg::TICK_BITS-1:0]   r_phase, n_phase;
    logic signed [fms_pkg::RATE_W-1:0] r_acc, n_acc;
    logic                            r_issued, n_issued;
    logic [fms_pkg::TRIG_W-1:0]      r_press, n_press;

    logic                        r_btn, n_btn, r_ang, n_ang, r_abort, n_abort;
    logic [fms_pkg::TRIM_W-1:0]  r_trim, n_trim;

    logic                              r_out_valid, n_out_valid;
    logic                              r_o_active, n_o_active;
    logic signed [fms_pkg::RATE_W-1:0] r_o_rate, n_o_rate;
    logic [fms_pkg::DUTY_W-1:0]        r_o_thrust, n_o_thrust;
    logic                              r_o_pulse, n_o_pulse;
    logic                              r_o_done, n_o_done;

    logic                          mul_en;
    logic [fms_pkg::MUL_W-1:0]     mul_a, mul_b;
    logic [fms_pkg::PROD_W-1:0]    mul_p;

    logic [fms_pkg::CMP_W-1:0] q, q3, b0, b1, b2, b3, b4, b5, c;
    logic                      at_max;
    logic [30:0]               trim_diff;
    logic [29:0]               trim_sum;
    logic [fms_pkg::PROD_W:0]  scaled_sum;
    logic [fms_pkg::DUTY_W-1:0] scaled;
    logic [15:0]               boosted_sum;
    logic [fms_pkg::DUTY_W-1:0] boosted;
    logic [fms_pkg::RATE_W:0]  acc_up, acc_dn;
    logic signed [fms_pkg::RATE_W-1:0] acc_up_sat, acc_dn_sat;
    logic [fms_pkg::TRIG_W:0]  press_inc;

    fms_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign q   = fms_pkg::CMP_W'(r_flip);
    assign q3  = q + (q << 1);
    assign b0  = fms_pkg::CMP_W'(r_pre);
    assign b1  = b0 + (q >> 2);
    assign b2  = b0 + (q >> 1);
    assign b3  = b0 + (q3 >> 2);
    assign b4  = b0 + q;
    assign b5  = b4 + fms_pkg::CMP_W'(r_post);
    assign c   = fms_pkg::CMP_W'(r_phase);
    assign at_max = (r_phase == {fms_pkg::TICK_BITS{1'b1}});

    assign trim_diff = {2'b00, fms_pkg::TRIM_OFFSET} - {1'b0, mul_p};
    assign trim_sum  = {1'b0, trim_diff[28:0]} + fms_pkg::ROUND_Q14;

    assign scaled_sum = {1'b0, mul_p} + fms_pkg::ROUND_Q16;
    assign scaled     = scaled_sum[fms_pkg::PROD_W:16];

    assign boosted_sum = {1'b0, r_trim} + {2'b00, r_boost};
    assign boosted     = boosted_sum[15] ? fms_pkg::DUTY_MAX : boosted_sum[14:0];

    assign acc_up = {r_acc[fms_pkg::RATE_W-1], r_acc}
                  + {{(fms_pkg::RATE_W + 1 - fms_pkg::STEP_W){1'b0}}, r_step};
    assign acc_dn = {r_acc[fms_pkg::RATE_W-1], r_acc}
                  - {{(fms_pkg::RATE_W + 1 - fms_pkg::STEP_W){1'b0}}, r_step};
    assign acc_up_sat = (acc_up[16] != acc_up[15]) ?
                        (acc_up[16] ? 16'sh8000 : 16'sh7FFF) : signed'(acc_up[15:0]);
    assign acc_dn_sat = (acc_dn[16] != acc_dn[15]) ?
                        (acc_dn[16] ? 16'sh8000 : 16'sh7FFF) : signed'(acc_dn[15:0]);

    assign press_inc = {1'b0, r_press} + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fms_pkg::S_IDLE;
            r_running   <= 1'b0;
            r_phase     <= '0;
            r_acc       <= '0;
            r_issued    <= 1'b0;
            r_press     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_issued    <= n_issued;
            r_press     <= n_press;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_btn      <= n_btn;
        r_ang      <= n_ang;
        r_abort    <= n_abort;
        r_trim     <= n_trim;
        r_o_active <= n_o_active;
        r_o_rate   <= n_o_rate;
        r_o_thrust <= n_o_thrust;
        r_o_pulse  <= n_o_pulse;
        r_o_done   <= n_o_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig  <= fms_pkg::RST_TRIGGER_COUNT;
            r_pre   <= fms_pkg::RST_PRE_HOLD;
            r_flip  <= fms_pkg::RST_FLIP_TICKS;
            r_post  <= fms_pkg::RST_POST_HOLD;
            r_step  <= fms_pkg::RST_RATE_STEP;
            r_boost <= fms_pkg::RST_BOOST_DUTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fms_pkg::CFG_TRIGGER_COUNT: r_trig  <= i_cfg_data[fms_pkg::TRIG_W-1:0];
                fms_pkg::CFG_PRE_HOLD:      r_pre   <= i_cfg_data[fms_pkg::TICKC_W-1:0];
                fms_pkg::CFG_FLIP_TICKS:    r_flip  <= i_cfg_data[fms_pkg::TICKC_W-1:0];
                fms_pkg::CFG_POST_HOLD:     r_post  <= i_cfg_data[fms_pkg::TICKC_W-1:0];
                fms_pkg::CFG_RATE_STEP:     r_step  <= i_cfg_data[fms_pkg::STEP_W-1:0];
                fms_pkg::CFG_BOOST_DUTY:    r_boost <= i_cfg_data[fms_pkg::BOOST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_issued    = r_issued;
        n_press     = r_press;
        n_btn       = r_btn;
        n_ang       = r_ang;
        n_abort     = r_abort;
        n_trim      = r_trim;
        n_out_valid = r_out_valid;
        n_o_active  = r_o_active;
        n_o_rate    = r_o_rate;
        n_o_thrust  = r_o_thrust;
        n_o_pulse   = r_o_pulse;
        n_o_done    = r_o_done;
        mul_en      = 1'b0;
        mul_a       = i_item.battery_volts;
        mul_b       = fms_pkg::TRIM_SLOPE;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fms_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    mul_en  = 1'b1;
                    n_btn   = i_item.flip_button;
                    n_ang   = i_item.angle_mode;
                    n_abort = i_item.abort;
                    n_state = fms_pkg::S_TRIM;
                end
            end
            fms_pkg::S_TRIM: begin
                n_trim  = trim_diff[30] ? '0 : trim_sum[28:14];
                n_state = fms_pkg::S_SCALE;
            end
            fms_pkg::S_SCALE: begin
                mul_en  = 1'b1;
                mul_a   = r_trim;
                mul_b   = (c < b1) ? fms_pkg::K_030 : fms_pkg::K_015;
                n_state = fms_pkg::S_FIN;
            end
            fms_pkg::S_FIN: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_o_active  = 1'b0;
                    n_o_rate    = '0;
                    n_o_thrust  = '0;
                    n_o_pulse   = 1'b0;
                    n_o_done    = 1'b0;
                    n_state     = fms_pkg::S_IDLE;
                    if (r_abort) begin
                        n_running = 1'b0;
                        n_phase   = '0;
                        n_acc     = '0;
                        n_issued  = 1'b0;
                        n_press   = '0;
                    end else begin
                        if (!r_running) begin
                            if (r_btn) begin
                                if (press_inc > {1'b0, r_trig}) begin
                                    n_press   = '0;
                                    n_running = 1'b1;
                                end else begin
                                    n_press = press_inc[fms_pkg::TRIG_W-1:0];
                                end
                            end else begin
                                n_press = '0;
                            end
                        end
                        if (r_ang) begin
                            if (n_running) begin
                                if (c >= b5 || at_max) begin
                                    n_running = 1'b0;
                                    n_issued  = 1'b0;
                                    n_acc     = '0;
                                    n_phase   = '0;
                                    n_o_done  = 1'b1;
                                end else begin
                                    n_o_active = 1'b1;
                                    if (c < b0) begin
                                        n_acc      = '0;
                                        n_o_thrust = boosted;
                                    end else if (c < b1) begin
                                        n_acc      = acc_up_sat;
                                        n_o_thrust = scaled;
                                    end else if (c < b2) begin
                                        n_acc      = acc_up_sat;
                                        n_o_thrust = scaled;
                                    end else if (c < b3) begin
                                        n_acc      = acc_dn_sat;
                                        n_o_thrust = scaled;
                                    end else if (c < b4) begin
                                        n_acc      = acc_dn_sat;
                                        n_o_thrust = r_trim;
                                    end else begin
                                        if (!r_issued) begin
                                            n_issued  = 1'b1;
                                            n_o_pulse = 1'b1;
                                        end
                                        n_acc      = '0;
                                        n_o_thrust = boosted;
                                    end
                                    n_o_rate = n_acc;
                                    n_phase  = r_phase + 1'b1;
                                end
                            end else begin
                                n_acc    = '0;
                                n_issued = 1'b0;
                                n_phase  = '0;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = fms_pkg::S_IDLE;
            end
        endcase
    end

    assign i_item.ready            = (r_state == fms_pkg::S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.flip_active    = r_o_active;
    assign o_result.roll_rate_ref  = r_o_rate;
    assign o_result.thrust_duty    = r_o_thrust;
    assign o_result.attitude_reset = r_o_pulse;
    assign o_result.flip_done      = r_o_done;

`ifndef NO_ASSERTIONS
    a_accept_to_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == fms_pkg::S_TRIM))
        else $error("accepted item did not start the trim step");

    a_pulse_in_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.attitude_reset) |-> o_result.flip_active)
        else $error("attitude reset outside an active flip");

    a_done_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.flip_done && o_result.flip_active))
        else $error("flip done while still active");

    a_issued_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_issued)
        else $error("reset flag kept with no flip running");
`endif

endmodule
